// File: hw/rtl/krl_pkg.sv
package krl_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_PREPEND = 3'd1;
    localparam logic [2:0] OP_ORDERED = 3'd2;
    localparam logic [2:0] OP_RM_LAST = 3'd3;
    localparam logic [2:0] OP_RM_FRST = 3'd4;
    localparam logic [2:0] OP_RM_KEY  = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;
    localparam logic [2:0] OP_FIND    = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] key;
        logic [63:0] name_tag;
        logic [15:0] grade_one;
        logic [15:0] grade_two;
        logic [15:0] grade_three;
        logic [6:0]  position;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] found_key;
        logic [63:0] found_name;
        logic [15:0] found_grade_one;
        logic [15:0] found_grade_two;
        logic [15:0] found_grade_three;
        logic [7:0]  entry_total;
        logic        is_full;
        logic        is_empty;
    } rsp_t;

    // one stored record: key, name, grades three/two/one
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] name;
        logic [47:0] grades;
    } rec_t;

endpackage

// File: hw/rtl/krl_store.sv
module krl_store #(
    parameter int CAPACITY = krl_pkg::CAPACITY_DEF,
    parameter int AW = $clog2(CAPACITY)
) (
    input  logic           aclk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  krl_pkg::rec_t  wr_data,
    input  logic [AW-1:0]  rd_addr,
    output krl_pkg::rec_t  rd_data
);
    import krl_pkg::*;

    rec_t mem [CAPACITY];

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/keyed_record_list.sv
// keyed_record_list: fixed-capacity array list of keyed records.
// Input channel s_valid/s_ready/s_data takes one request beat; result
// channel m_valid/m_ready/m_data returns exactly one result beat each.
// The block holds one request at a time: s_ready is low from acceptance
// until the result has been taken.
// All work runs through one record memory with a single write port and a
// registered read. Each entry compared passes a scan and a compare state;
// each entry moved passes a move-read and a move-write state. Find, remove
// by key and ordered insert scan; prepend, remove first and the shifting
// inserts and removes move entries; append, remove last and read do
// neither. Ordered insert and remove by key scan, then shift.
// Reset (aresetn low, synchronous) empties the list at once; the record
// memory is not cleared since entries beyond the fill count are never read.
// If the receiver stalls, the result holds in m_data and no new request
// is taken until it is accepted.
module keyed_record_list #(
    parameter int CAPACITY = krl_pkg::CAPACITY_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  krl_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output krl_pkg::rsp_t m_data
);
    import krl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;   // issue read at idx
    localparam logic [2:0] ST_CMP  = 3'd2;   // data for idx available
    localparam logic [2:0] ST_MVRD = 3'd3;   // issue read for move
    localparam logic [2:0] ST_MVWR = 3'd4;   // write moved entry
    localparam logic [2:0] ST_FIN  = 3'd5;   // final write / readout
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan / move cursor
    logic [CW-1:0] at_reg, at_next;       // target slot
    req_t          req_reg, req_next;
    rsp_t          rsp_reg, rsp_next;
    logic          m_valid_reg, m_valid_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    rec_t          wr_data, rd_data, new_rec;

    krl_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign new_rec = '{key: req_reg.key, name: req_reg.name_tag,
                       grades: {req_reg.grade_three, req_reg.grade_two,
                                req_reg.grade_one}};
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // sequencer
    always_comb begin
        logic          is_ins;
        logic          shift_up;
        logic [CW-1:0] nfill;
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        at_next      = at_reg;
        req_next     = req_reg;
        rsp_next     = rsp_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        wr_addr      = at_reg[AW-1:0];
        wr_data      = new_rec;
        rd_addr      = idx_reg[AW-1:0];
        is_ins   = (req_reg.req_type == OP_APPEND) || (req_reg.req_type == OP_PREPEND)
                   || (req_reg.req_type == OP_ORDERED);
        shift_up = is_ins;
        nfill    = fill_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    rsp_next = '0;
                    idx_next = '0;
                    state_next = ST_FIN;
                    case (s_data.req_type)
                        OP_APPEND, OP_PREPEND, OP_ORDERED: begin
                            if (fill_reg == CAP_C) begin
                                state_next = ST_OUT;
                            end else if (s_data.req_type == OP_APPEND) begin
                                at_next = fill_reg;
                            end else if (s_data.req_type == OP_PREPEND) begin
                                at_next  = '0;
                                idx_next = fill_reg;
                                state_next = ST_MVRD;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_RM_LAST, OP_RM_FRST: begin
                            if (fill_reg == '0) begin
                                state_next = ST_OUT;
                            end else if (s_data.req_type == OP_RM_LAST) begin
                                at_next = fill_reg - CW'(1);
                            end else begin
                                at_next  = '0;
                                idx_next = '0;
                                state_next = ST_MVRD;
                            end
                        end
                        OP_READ: begin
                            // issue the read now so the entry is ready in finish
                            if ({25'b0, s_data.position} < 32'(fill_reg)) begin
                                idx_next = CW'(s_data.position);
                                at_next  = CW'(s_data.position);
                                rd_addr  = AW'(s_data.position);
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (idx_reg >= fill_reg) begin
                    // ran off the end
                    if (req_reg.req_type == OP_ORDERED) begin
                        at_next = fill_reg;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (req_reg.req_type == OP_ORDERED ? !(rd_data.key < req_reg.key)
                                                   : (rd_data.key == req_reg.key)) begin
                    at_next = idx_reg;
                    if (req_reg.req_type == OP_FIND) begin
                        rsp_next.ok = 1'b1;
                        rsp_next.found_key  = rd_data.key;
                        rsp_next.found_name = rd_data.name;
                        rsp_next.found_grade_one   = rd_data.grades[15:0];
                        rsp_next.found_grade_two   = rd_data.grades[31:16];
                        rsp_next.found_grade_three = rd_data.grades[47:32];
                        state_next = ST_OUT;
                    end else if (req_reg.req_type == OP_ORDERED) begin
                        idx_next = fill_reg;
                        state_next = ST_MVRD;
                    end else begin
                        state_next = ST_MVRD;
                    end
                end else begin
                    idx_next = idx_reg + CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_MVRD: begin
                // up: move idx-1 -> idx while idx > at; down: idx+1 -> idx
                if (shift_up) begin
                    if (idx_reg > at_reg) begin
                        rd_addr = AW'(idx_reg - CW'(1));
                        state_next = ST_MVWR;
                    end else begin
                        state_next = ST_FIN;
                    end
                end else begin
                    if (idx_reg + CW'(1) < fill_reg) begin
                        rd_addr = AW'(idx_reg + CW'(1));
                        state_next = ST_MVWR;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MVWR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data;
                idx_next = shift_up ? idx_reg - CW'(1) : idx_reg + CW'(1);
                state_next = ST_MVRD;
            end
            ST_FIN: begin
                state_next = ST_OUT;
                rsp_next.ok = 1'b1;
                if (is_ins) begin
                    wr_en = 1'b1;
                    nfill = fill_reg + CW'(1);
                end else if (req_reg.req_type == OP_READ) begin
                    rsp_next.found_key  = rd_data.key;
                    rsp_next.found_name = rd_data.name;
                    rsp_next.found_grade_one   = rd_data.grades[15:0];
                    rsp_next.found_grade_two   = rd_data.grades[31:16];
                    rsp_next.found_grade_three = rd_data.grades[47:32];
                end else begin
                    nfill = fill_reg - CW'(1);
                end
                fill_next = nfill;
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    rsp_next.entry_total = 8'(fill_reg);
                    rsp_next.is_full  = (fill_reg == CAP_C);
                    rsp_next.is_empty = (fill_reg == '0);
                    m_valid_next = 1'b1;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg <= idx_next;
        at_reg  <= at_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // fill count never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= CAP_C)
        else $error("fill count above capacity");
    // no new request while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid_reg |-> !s_ready)
        else $error("ready while result pending");
    // fill count changes only after the finish state, so at most once per request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != $past(fill_reg)) |-> ($past(state_reg) == ST_FIN))
        else $error("fill count changed outside finish");

endmodule
